/* src/kda_pkg.sv */
// ----------------------------------------------------------------------------
// kda_pkg
// Shared constants, types and codes for the key debounce / autorepeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package kda_pkg;

  localparam int NUM_KEYS   = 8;
  localparam int COUNT_BITS = 16;
  localparam int LEVEL_W    = 8;    // width of the key_levels field
  localparam int KEY_W      = 3;    // width of the key_index field
  localparam int DELAY_W    = 16;   // width of each delay register
  localparam int CFG_AW     = 2;    // config register index width
  localparam int IDX_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CMP_W      = (COUNT_BITS > DELAY_W) ? COUNT_BITS : DELAY_W;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [CFG_AW-1:0] REG_PRESS_DELAY     = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_HOLD_DELAY      = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_REPEAT_INTERVAL = CFG_AW'(2);

  localparam logic [DELAY_W-1:0] PRESS_DELAY_RST     = DELAY_W'(3);
  localparam logic [DELAY_W-1:0] HOLD_DELAY_RST      = DELAY_W'(50);
  localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RST = DELAY_W'(10);

  // Per-key debounce state; code 3 is never produced.
  typedef enum logic [1:0] {
    KS_OFF = 2'd0,
    KS_ON  = 2'd1,
    KS_REP = 2'd2
  } key_st_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SCAN,
    SC_FLUSH
  } scan_st_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             is_make;
    logic             last_event;
  } evt_t;

  typedef struct packed {
    logic valid;
    evt_t evt;
  } evt_req_t;

endpackage

`default_nettype wire

/* src/kda_front.sv */
// ----------------------------------------------------------------------------
// kda_front
// Accepts a scan tick, walks the keys one per cycle while the event queue is
// not full, updates their state and counters and pushes events; the last event
// of a tick is held back until the walk ends so that it can be flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module kda_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [kda_pkg::LEVEL_W-1:0]   levels_in,
  input  wire logic                          cfg_we,
  input  wire logic [kda_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [kda_pkg::DELAY_W-1:0]   cfg_data,
  input  wire logic                          q_full,
  output kda_pkg::evt_req_t                  q_push
);

  localparam logic [kda_pkg::COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [kda_pkg::IDX_W-1:0] IDX_LAST = kda_pkg::IDX_W'(kda_pkg::NUM_KEYS - 1);

  kda_pkg::scan_st_t state, state_next;

  kda_pkg::key_st_t                  kst [kda_pkg::NUM_KEYS];
  logic [kda_pkg::COUNT_BITS-1:0]    kcnt [kda_pkg::NUM_KEYS];

  logic [kda_pkg::DELAY_W-1:0] press_delay, hold_delay, repeat_interval;

  logic [kda_pkg::IDX_W-1:0]   idx;
  logic [kda_pkg::LEVEL_W-1:0] levels;
  logic                        pend_v, pend_v_next;
  kda_pkg::evt_t               pend, pend_next;

  // working values for the key under the scan pointer
  logic [kda_pkg::LEVEL_W+kda_pkg::NUM_KEYS-1:0] lv_ext;
  logic [kda_pkg::IDX_W+kda_pkg::KEY_W-1:0]      idx_ext;
  kda_pkg::key_st_t                  cur_st, new_st;
  logic [kda_pkg::COUNT_BITS-1:0]    cur_cnt, cnt_inc, new_cnt;
  logic                              pressed, emit, make, step;

  assign lv_ext  = {kda_pkg::NUM_KEYS'(0), levels};
  assign idx_ext = {kda_pkg::KEY_W'(0), idx};
  assign pressed = lv_ext[idx];
  assign cur_st  = kst[idx];
  assign cur_cnt = kcnt[idx];
  assign cnt_inc = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign step    = (state == kda_pkg::SC_SCAN) && !q_full;
  assign s_tready = (state == kda_pkg::SC_IDLE);

  always_comb begin
    new_st  = cur_st;
    new_cnt = cur_cnt;
    emit    = 1'b0;
    make    = 1'b0;
    if (cur_st != kda_pkg::KS_OFF && !pressed) begin
      new_st  = kda_pkg::KS_OFF;
      new_cnt = '0;
      emit    = 1'b1;
    end else if (cur_st == kda_pkg::KS_OFF && pressed) begin
      new_cnt = cnt_inc;
      if (kda_pkg::CMP_W'(cnt_inc) >= kda_pkg::CMP_W'(press_delay)) begin
        new_st  = kda_pkg::KS_ON;
        new_cnt = '0;
        emit    = 1'b1;
        make    = 1'b1;
      end
    end else if (pressed) begin
      new_cnt = cnt_inc;
      if (cur_st == kda_pkg::KS_ON &&
          kda_pkg::CMP_W'(cnt_inc) >= kda_pkg::CMP_W'(hold_delay)) begin
        new_st  = kda_pkg::KS_REP;
        new_cnt = '0;
        emit    = 1'b1;
        make    = 1'b1;
      end else if (cur_st == kda_pkg::KS_REP &&
                   kda_pkg::CMP_W'(cnt_inc) >= kda_pkg::CMP_W'(repeat_interval)) begin
        new_cnt = '0;
        emit    = 1'b1;
        make    = 1'b1;
      end
    end
  end

  // scan sequencer: next state, held event and queue push
  always_comb begin
    state_next  = state;
    pend_v_next = pend_v;
    pend_next   = pend;
    q_push      = '0;
    unique case (state)
      kda_pkg::SC_IDLE: begin
        if (s_tvalid) begin
          state_next  = kda_pkg::SC_SCAN;
          pend_v_next = 1'b0;
        end
      end
      kda_pkg::SC_SCAN: begin
        if (step) begin
          if (emit) begin
            q_push.valid = pend_v;
            q_push.evt   = pend;
            pend_v_next  = 1'b1;
            pend_next.key_index  = idx_ext[kda_pkg::KEY_W-1:0];
            pend_next.is_make    = make;
            pend_next.last_event = 1'b0;
          end
          if (idx == IDX_LAST) begin
            state_next = kda_pkg::SC_FLUSH;
          end
        end
      end
      kda_pkg::SC_FLUSH: begin
        if (!pend_v) begin
          state_next = kda_pkg::SC_IDLE;
        end else if (!q_full) begin
          q_push.valid          = 1'b1;
          q_push.evt            = pend;
          q_push.evt.last_event = 1'b1;
          pend_v_next           = 1'b0;
          state_next            = kda_pkg::SC_IDLE;
        end
      end
      default: begin
        state_next = kda_pkg::SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= kda_pkg::SC_IDLE;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      pend_v <= pend_v_next;
    end
    pend <= pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (s_tvalid && s_tready) begin
      idx <= '0;
    end else if (step && idx != IDX_LAST) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      levels <= levels_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < kda_pkg::NUM_KEYS; k++) begin
        kst[k]  <= kda_pkg::KS_OFF;
        kcnt[k] <= '0;
      end
    end else if (step) begin
      kst[idx]  <= new_st;
      kcnt[idx] <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_delay     <= kda_pkg::PRESS_DELAY_RST;
      hold_delay      <= kda_pkg::HOLD_DELAY_RST;
      repeat_interval <= kda_pkg::REPEAT_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kda_pkg::REG_PRESS_DELAY:     press_delay     <= cfg_data;
        kda_pkg::REG_HOLD_DELAY:      hold_delay      <= cfg_data;
        kda_pkg::REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/kda_fifo.sv */
// ----------------------------------------------------------------------------
// kda_fifo
// Short event queue between the key scanner and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kda_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kda_pkg::evt_req_t push,
  input  wire logic              pop,
  output logic                   full,
  output logic                   empty,
  output kda_pkg::evt_t          rdata
);

  kda_pkg::evt_t                mem [kda_pkg::FIFO_DEPTH];
  logic [kda_pkg::FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic [kda_pkg::FIFO_AW:0]    count;
  logic                         do_push, do_pop;

  assign full    = (count == (kda_pkg::FIFO_AW+1)'(kda_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.evt;
    end
  end

endmodule

`default_nettype wire

/* src/kda_back.sv */
// ----------------------------------------------------------------------------
// kda_back
// Output register: pulls events from the queue and presents them on the
// master stream until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kda_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire kda_pkg::evt_t q_data,
  output logic               q_pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tlast
);

  kda_pkg::evt_t out_evt;

  assign q_pop   = !q_empty && (!m_tvalid || m_tready);
  assign m_tdata = 8'({out_evt.is_make, out_evt.key_index});
  assign m_tlast = out_evt.last_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_evt <= q_data;
    end
  end

endmodule

`default_nettype wire

/* src/key_debounce_autorepeat.sv */
// ----------------------------------------------------------------------------
// key_debounce_autorepeat
// Keypad debounce with press, hold-to-repeat and release events.
// ----------------------------------------------------------------------------
// Each scan tick on the slave stream carries one pressed bit per key. The
// scanner walks the keys one per clock and then flags the last event, both
// waiting while the four-entry event queue is full; the input takes no new
// tick until that is done. Events leave on the master stream in ascending key
// order as {is_make, key_index}; tlast marks the last event of a tick, and a
// tick with no events produces nothing. Delay registers are written through
// cfg_we/cfg_addr/cfg_data (0 press_delay, 1 hold_delay, 2 repeat_interval);
// write them only while no tick is in flight, which the block does not enforce.
`default_nettype none

module key_debounce_autorepeat (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // [7:0] key_levels
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,   // [2:0] key_index, [3] is_make, [7:4] zero
  output logic                             m_tlast,
  input  wire logic                        cfg_we,
  input  wire logic [kda_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [kda_pkg::DELAY_W-1:0] cfg_data
);

  kda_pkg::evt_req_t q_push;
  kda_pkg::evt_t     q_data;
  logic              q_full, q_empty, q_pop;

  kda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .levels_in (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  kda_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_data)
  );

  kda_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

/* src/kda_checker.sv */
// ----------------------------------------------------------------------------
// kda_checker
// Port-level checks for the key debounce block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kda_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // an accepted tick drops s_tready, as the scanner leaves idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted on back-to-back cycles");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] == 4'b0)
    else $error("padding bits set");

endmodule

bind key_debounce_autorepeat kda_checker u_kda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* test/key_debounce_autorepeat_tb.sv */
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_tb
// Self-checking bench for the keypad debounce / autorepeat block. Scan ticks
// go in on the slave stream and are predicted per key (off/on/repeating,
// saturating counter) as they are taken; each event on the master stream is
// checked in order against the prediction. Directed ticks cover full-row
// press and release, partial counts and zero delays; the rest is random
// key-hold sequences with some noise, under several delay settings, with
// random gaps on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_debounce_autorepeat_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 2 * (kda_pkg::NUM_KEYS + 1) + 4;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [kda_pkg::LEVEL_W-1:0]   s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [7:0]                    m_tdata;
  logic                          m_tlast;
  logic                          cfg_we = 1'b0;
  logic [kda_pkg::CFG_AW-1:0]    cfg_addr = kda_pkg::REG_PRESS_DELAY;
  logic [kda_pkg::DELAY_W-1:0]   cfg_data = '0;

  key_debounce_autorepeat dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),     // [7:0] key_levels
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),     // [2:0] key_index, [3] is_make, [7:4] zero
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  kda_pkg::key_st_t               key_mode   [kda_pkg::NUM_KEYS];
  logic [kda_pkg::COUNT_BITS-1:0] hold_count [kda_pkg::NUM_KEYS];
  logic [kda_pkg::DELAY_W-1:0]    press_dly = kda_pkg::PRESS_DELAY_RST;
  logic [kda_pkg::DELAY_W-1:0]    hold_dly  = kda_pkg::HOLD_DELAY_RST;
  logic [kda_pkg::DELAY_W-1:0]    rep_ivl   = kda_pkg::REPEAT_INTERVAL_RST;

  kda_pkg::evt_t                  pending_events[$];
  logic [kda_pkg::LEVEL_W-1:0]    scan_ticks[$];
  int                             ticks_queued = 0;
  int                             ticks_taken = 0;
  int                             mismatches = 0;
  int                             tx_gap_pct = 30;
  int                             rx_stall_pct = 30;
  int                             tx_gap = 0;
  int                             rx_stall = 0;
  int                             holdoff_req = 0;
  int                             hold_left = 0;
  int                             cycles = 0;
  logic [kda_pkg::LEVEL_W-1:0]    key_held = '0;
  kda_pkg::evt_t                  want;

  initial begin
    for (int k = 0; k < kda_pkg::NUM_KEYS; k++) begin
      key_mode[k]   = kda_pkg::KS_OFF;
      hold_count[k] = '0;
    end
  end

  // One scan tick through the per-key state machines; events are appended in
  // ascending key order and the last one of the tick gets the flag.
  function automatic void debounce_tick(input logic [kda_pkg::LEVEL_W-1:0] levels);
    int            first;
    logic          fire;
    logic          mk;
    kda_pkg::evt_t ev;
    first = pending_events.size();
    for (int k = 0; k < kda_pkg::NUM_KEYS; k++) begin
      fire = 1'b0;
      mk   = 1'b0;
      if (key_mode[k] != kda_pkg::KS_OFF && !levels[k]) begin
        key_mode[k]   = kda_pkg::KS_OFF;
        hold_count[k] = '0;
        fire = 1'b1;
      end else if (levels[k]) begin
        if (hold_count[k] != '1) hold_count[k] = hold_count[k] + 1'b1;
        if (key_mode[k] == kda_pkg::KS_OFF && hold_count[k] >= press_dly) begin
          key_mode[k] = kda_pkg::KS_ON;
          fire = 1'b1;
        end else if (key_mode[k] == kda_pkg::KS_ON && hold_count[k] >= hold_dly) begin
          key_mode[k] = kda_pkg::KS_REP;
          fire = 1'b1;
        end else if (key_mode[k] == kda_pkg::KS_REP && hold_count[k] >= rep_ivl) begin
          fire = 1'b1;
        end
        if (fire) begin
          hold_count[k] = '0;
          mk = 1'b1;
        end
      end
      if (fire) begin
        ev.key_index  = kda_pkg::KEY_W'(k);
        ev.is_make    = mk;
        ev.last_event = 1'b0;
        pending_events.push_back(ev);
      end
    end
    if (pending_events.size() > first) begin
      ev = pending_events.pop_back();
      ev.last_event = 1'b1;
      pending_events.push_back(ev);
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        debounce_tick(s_tdata);
        ticks_taken <= ticks_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (scan_ticks.size() > 0) begin
          s_tdata  <= scan_ticks.pop_front();
          s_tvalid <= 1'b1;
          tx_gap = pick_gap(tx_gap_pct);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and event check
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_events.size() == 0) begin
          log_mismatch($sformatf("unexpected event: key %0d make %0b last %0b",
                                 m_tdata[kda_pkg::KEY_W-1:0], m_tdata[kda_pkg::KEY_W],
                                 m_tlast));
        end else begin
          want = pending_events.pop_front();
          if (m_tdata[kda_pkg::KEY_W-1:0] !== want.key_index ||
              m_tdata[kda_pkg::KEY_W] !== want.is_make ||
              m_tdata[7:kda_pkg::KEY_W+1] !== '0 || m_tlast !== want.last_event)
            log_mismatch($sformatf(
              "event mismatch: exp key %0d make %0b last %0b, got key %0d make %0b last %0b pad %h",
              want.key_index, want.is_make, want.last_event, m_tdata[kda_pkg::KEY_W-1:0],
              m_tdata[kda_pkg::KEY_W], m_tlast, m_tdata[7:kda_pkg::KEY_W+1]));
        end
      end
      if (rx_stall > 0) rx_stall--;
      else rx_stall = pick_gap(rx_stall_pct);
      m_tready <= (rx_stall == 0) && (hold_left == 0);
    end
  end

  // long receiver hold-off, started on request
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (holdoff_req != 0) begin
      hold_left <= holdoff_req;
      holdoff_req = 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_tick(input logic [kda_pkg::LEVEL_W-1:0] levels);
    scan_ticks.push_back(levels);
    ticks_queued++;
  endtask

  // keys held for random stretches, with an occasional random row
  task automatic push_walk(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        push_tick(kda_pkg::LEVEL_W'($urandom));
      end else begin
        for (int k = 0; k < kda_pkg::NUM_KEYS; k++)
          if ($urandom_range(5) == 0) key_held[k] = ~key_held[k];
        push_tick(key_held);
      end
    end
  endtask

  // all ticks taken, all events seen, plus time for a tick with no events
  task automatic wait_idle();
    while (scan_ticks.size() != 0 || ticks_taken != ticks_queued || pending_events.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_delays(input logic [kda_pkg::DELAY_W-1:0] p,
                            input logic [kda_pkg::DELAY_W-1:0] h,
                            input logic [kda_pkg::DELAY_W-1:0] r);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= kda_pkg::REG_PRESS_DELAY;
    cfg_data <= p;
    @(posedge clk);
    cfg_addr <= kda_pkg::REG_HOLD_DELAY;
    cfg_data <= h;
    @(posedge clk);
    cfg_addr <= kda_pkg::REG_REPEAT_INTERVAL;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    press_dly = p;
    hold_dly  = h;
    rep_ivl   = r;
    @(negedge clk);
  endtask

  initial begin
    logic [kda_pkg::LEVEL_W-1:0] directed[$];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset delays: full row press/release, partial count kept on release
    directed = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h01, 8'h01,
                 8'h81, 8'h00, 8'h80, 8'h80, 8'h00, 8'h55, 8'h55, 8'h55, 8'hAA};
    foreach (directed[i]) push_tick(directed[i]);
    wait_idle();

    // zero delays: make, second make, repeat every tick
    set_delays('0, '0, '0);
    push_tick(8'h01);
    push_tick(8'h01);
    push_tick(8'h01);
    push_tick(8'h00);
    wait_idle();

    // receiver holds off while eight events per tick pile up
    tx_gap_pct = 0;
    repeat (30) push_tick(8'hFF);
    push_tick(8'h00);
    holdoff_req = 400;
    wait_idle();

    // all-ones delays: five full-row ticks and a release give no events
    tx_gap_pct = 30;
    set_delays('1, '1, '1);
    repeat (5) push_tick(8'hFF);
    push_tick(8'h00);
    wait_idle();
    set_delays(kda_pkg::DELAY_W'(1), '1, '0);
    push_walk(20);
    wait_idle();
    set_delays('0, kda_pkg::DELAY_W'(1), '1);
    push_walk(20);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      tx_gap_pct   = (ph == 2) ? 0 : 30;
      rx_stall_pct = (ph == 2) ? 0 : 30;
      set_delays(kda_pkg::DELAY_W'($urandom_range(3)), kda_pkg::DELAY_W'($urandom_range(8)),
                 kda_pkg::DELAY_W'($urandom_range(4)));
      push_walk(37);
      wait_idle();
    end

    // back to reset delays, one key held for a long stretch, then released
    set_delays(kda_pkg::PRESS_DELAY_RST, kda_pkg::HOLD_DELAY_RST,
               kda_pkg::REPEAT_INTERVAL_RST);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (75) push_tick(8'h04);
    push_tick(8'h00);
    wait_idle();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* key_debounce_autorepeat.f */
src/kda_pkg.sv
src/kda_front.sv
src/kda_fifo.sv
src/kda_back.sv
src/key_debounce_autorepeat.sv
src/kda_checker.sv
test/key_debounce_autorepeat_tb.sv
